// ===== hdl/ukt_pkg.sv =====
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared types and codes for the compacting unique-key table.
// ----------------------------------------------------------------------------
package ukt_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] entry_key;
    } ukt_req_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } ukt_rsp_t;

endpackage

// ===== hdl/unique_key_table_insert_delete_unit.sv =====
// ----------------------------------------------------------------------------
// unique_key_table_insert_delete_unit
// Compacting table of records with unique keys, packed in insertion order.
// ----------------------------------------------------------------------------
// One command at a time. An insert refused as full, and any command on an
// empty table, go straight to the result without a walk of the key RAM.
// Any other command walks the key RAM from entry 0, one entry per cycle
// through the registered read port, then a delete moves each later entry
// down by one at one entry per cycle through the same port. The result sits
// in an output register, so a finished result waiting on m_tready does not
// hold up the walk of the next command; a second finished result waits until
// that register drains. Read data from entries at or above the count is
// never used.
// ----------------------------------------------------------------------------
module unique_key_table_insert_delete_unit
    import ukt_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,    // capacity_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // entry_key[31:0], entry_data[63:32]
    input  logic        s_tuser,     // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // status[1:0], entry_count[9:2], zero pad
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [7:0]            cap_reg;
    logic                  m_tvalid_reg;
    logic [15:0]           m_tdata_reg;

    ukt_req_t              req;
    ukt_rsp_t              rsp;
    logic [63:0]           data_wide;
    logic [DATA_WIDTH-1:0] req_data;
    logic                  start;
    logic                  idle;
    logic                  out_free;
    logic                  out_load;

    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_W-1:0]      wr_key;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [KEY_W-1:0]      rd_key;
    logic [DATA_WIDTH-1:0] rd_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign start     = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = rsp.valid && out_free;

    assign req.action    = s_tuser;
    assign req.entry_key = s_tdata[31:0];
    assign data_wide     = {32'b0, s_tdata[63:32]};
    assign req_data      = data_wide[DATA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 8'd128;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {6'b0, rsp.entry_count, rsp.status};
        end
    end

    ukt_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .req_data  (req_data),
        .cap_limit (cap_reg),
        .out_free  (out_free),
        .idle      (idle),
        .rsp       (rsp),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_data   (wr_data),
        .rd_key    (rd_key),
        .rd_data   (rd_data)
    );

    ukt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_key),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    ukt_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready)
        else $error("input accepted while a command was still in flight");

    a_reply_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !s_tready)
        else $error("result offered while sequencer idle");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && !$past(s_tready))
        else $error("result register not loaded from a finished command");

endmodule

// ===== hdl/ukt_ram.sv =====
// ----------------------------------------------------------------------------
// ukt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ukt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ukt_seq.sv =====
// ----------------------------------------------------------------------------
// ukt_seq
// Sequencer: linear key search, append, and shift-down compaction over the
// key and data RAMs. Owns the fill count.
// ----------------------------------------------------------------------------
module ukt_seq
    import ukt_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  ukt_req_t                  req,
    input  logic [DATA_WIDTH-1:0]     req_data,
    input  logic [7:0]                cap_limit,
    input  logic                      out_free,
    output logic                      idle,
    output ukt_rsp_t                  rsp,
    output logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic                      wr_en,
    output logic [$clog2(DEPTH)-1:0]  wr_addr,
    output logic [KEY_W-1:0]          wr_key,
    output logic [DATA_WIDTH-1:0]     wr_data,
    input  logic [KEY_W-1:0]          rd_key,
    input  logic [DATA_WIDTH-1:0]     rd_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_REPLY
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      ptr_reg;
    logic                  action_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [CNT_W-1:0]      ptr_inc;
    logic [CNT_W-1:0]      ptr_dec;
    logic [CNT_W+7:0]      count_ext;
    logic [CNT_W+7:0]      cap_ext;
    logic [CNT_W+7:0]      count_low;
    logic                  full;
    logic                  last;
    logic                  hit;

    assign ptr_inc   = ptr_reg + 1'b1;
    assign ptr_dec   = ptr_reg - 1'b1;
    assign count_ext = {8'b0, count_reg};
    assign cap_ext   = {{CNT_W{1'b0}}, cap_limit};
    assign count_low = {8'b0, count_reg};
    assign full      = (count_reg == CNT_W'(DEPTH)) || (count_ext >= cap_ext);
    assign last      = (ptr_inc == count_reg);
    assign hit       = (rd_key == key_reg);

    assign idle            = (state_reg == S_IDLE);
    assign rsp.valid       = (state_reg == S_REPLY);
    assign rsp.status      = status_reg;
    assign rsp.entry_count = count_low[7:0];

    assign rd_addr = (state_reg == S_IDLE) ? '0 : ptr_inc[IDX_W-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_key  = key_reg;
        wr_data = data_reg;
        case (state_reg)
            S_IDLE:
            begin
                wr_key  = req.entry_key;
                wr_data = req_data;
                wr_en   = start && (req.action == ACT_INSERT) && !full
                          && (count_reg == '0);
            end
            S_SEARCH:
            begin
                wr_en = !hit && last && (action_reg == ACT_INSERT);
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_dec[IDX_W-1:0];
                wr_key  = rd_key;
                wr_data = rd_data;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            status_reg <= ST_DONE;
            action_reg <= ACT_INSERT;
            key_reg    <= '0;
            data_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        action_reg <= req.action;
                        key_reg    <= req.entry_key;
                        data_reg   <= req_data;
                        ptr_reg    <= '0;
                        if ((req.action == ACT_INSERT) && full)
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_REPLY;
                        end
                        else if (count_reg == '0)
                        begin
                            if (req.action == ACT_INSERT)
                            begin
                                count_reg  <= count_reg + 1'b1;
                                status_reg <= ST_DONE;
                            end
                            else
                            begin
                                status_reg <= ST_MISSING;
                            end
                            state_reg <= S_REPLY;
                        end
                        else
                        begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (hit)
                    begin
                        if (action_reg == ACT_INSERT)
                        begin
                            status_reg <= ST_DUP;
                            state_reg  <= S_REPLY;
                        end
                        else if (last)
                        begin
                            count_reg  <= count_reg - 1'b1;
                            status_reg <= ST_DONE;
                            state_reg  <= S_REPLY;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_inc;
                            state_reg <= S_SHIFT;
                        end
                    end
                    else if (last)
                    begin
                        if (action_reg == ACT_INSERT)
                        begin
                            count_reg  <= count_reg + 1'b1;
                            status_reg <= ST_DONE;
                        end
                        else
                        begin
                            status_reg <= ST_MISSING;
                        end
                        state_reg <= S_REPLY;
                    end
                    else
                    begin
                        ptr_reg <= ptr_inc;
                    end
                end
                S_SHIFT:
                begin
                    if (last)
                    begin
                        count_reg  <= count_reg - 1'b1;
                        status_reg <= ST_DONE;
                        state_reg  <= S_REPLY;
                    end
                    else
                    begin
                        ptr_reg <= ptr_inc;
                    end
                end
                S_REPLY:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
